FILE: hw/rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg: shared definitions for the encoder frame receiver
// Sizes, register indexes, reset values and the record types that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

  // Frame buffer geometry.
  localparam int unsigned FRAME_BYTES         = 12;
  localparam int unsigned POSITION_HIGH_INDEX = 8;
  localparam int unsigned IDX_W               = $clog2(FRAME_BYTES);

  // Queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned OFFSET_W   = 24;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned HEAD_W     = 23;
  localparam int unsigned PROD_W     = POS_W + GAIN_W;
  localparam int unsigned DIFF_W     = PROD_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Heading saturation limits.
  localparam logic signed [DIFF_W-1:0] HEAD_MAX = DIFF_W'((1 << (HEAD_W - 1)) - 1);
  localparam logic signed [DIFF_W-1:0] HEAD_MIN = DIFF_W'(-(1 << (HEAD_W - 1)));

  // Register reset values.
  localparam logic [BYTE_W-1:0]   RST_START_MARKER    = 8'd170;
  localparam logic [POS_W-1:0]    RST_POSITION_MIN    = 16'd12;
  localparam logic [POS_W-1:0]    RST_POSITION_MAX    = 16'd3943;
  localparam logic [GAIN_W-1:0]   RST_HEADING_GAIN    = 16'd1167;
  localparam logic [OFFSET_W-1:0] RST_HEADING_OFFSET  = 24'd2306867;
  localparam logic [COUNT_W-1:0]  RST_IDLE_TIMEOUT_MS = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER    = 3'd0,
    REG_POSITION_MIN    = 3'd1,
    REG_POSITION_MAX    = 3'd2,
    REG_HEADING_GAIN    = 3'd3,
    REG_HEADING_OFFSET  = 3'd4,
    REG_IDLE_TIMEOUT_MS = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   start_marker;
    logic [POS_W-1:0]    position_min;
    logic [POS_W-1:0]    position_max;
    logic [GAIN_W-1:0]   heading_gain;
    logic [OFFSET_W-1:0] heading_offset;
    logic [COUNT_W-1:0]  idle_timeout_ms;
  } cfg_t;

  // One classified item as the front end hands it to the back end.
  typedef struct packed {
    logic             frame_done;
    logic [POS_W-1:0] raw_position;
    logic [POS_W-1:0] held_position;
    logic             link_up;
    logic             link_changed;
  } q_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/efr_if.sv
// ----------------------------------------------------------------------------
// efr_if: handshake channels of the encoder frame receiver
// Input item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface efr_in_if;
  import efr_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface efr_out_if;
  import efr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     frame_done;
  logic [POS_W-1:0]         raw_position;
  logic [POS_W-1:0]         clamped_position;
  logic signed [HEAD_W-1:0] heading_q16;
  logic                     link_up;
  logic                     link_changed;

  modport source (output valid, output frame_done, output raw_position,
                  output clamped_position, output heading_q16, output link_up,
                  output link_changed, input ready);
  modport sink (input valid, input frame_done, input raw_position,
                input clamped_position, input heading_q16, input link_up,
                input link_changed, output ready);
endinterface

interface efr_cfg_if;
  import efr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/efr_front.sv
// ----------------------------------------------------------------------------
// efr_front: frame and link tracking
// Accepts bytes and ticks, updates the frame buffer and link state, and
// pushes one classified record per beat into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  efr_in_if.sink                item_i,
  input  wire efr_pkg::cfg_t    cfg_i,
  input  wire logic             queue_full_i,
  output logic                  push_o,
  output efr_pkg::q_entry_t     entry_o
);
  import efr_pkg::*;

  logic [BYTE_W-1:0]   frame_q [FRAME_BYTES];
  logic [BYTE_W-1:0]   frame_d [FRAME_BYTES];
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                in_frame_q, in_frame_d;
  logic [POS_W-1:0]    held_q, held_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic                link_q, link_d, link_tmp;
  logic                reported_q, reported_d;
  logic                accept;
  logic                closing;
  logic [BYTE_W-1:0]   pos_hi, pos_lo;
  logic [POS_W-1:0]    raw_d;

  assign accept       = item_i.valid && item_i.ready;
  assign item_i.ready = !queue_full_i;

  always_comb begin
    frame_d    = frame_q;
    idx_d      = idx_q;
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    link_tmp   = link_q;
    closing    = 1'b0;
    if (accept) begin
      if (op_e'(item_i.opcode) == OP_TICK) begin
        if (cnt_q != '1) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        link_tmp = 1'b1;
        cnt_d    = '0;
        if (in_frame_q) begin
          if (item_i.rx_byte != cfg_i.start_marker) begin
            frame_d[idx_q] = item_i.rx_byte;
            if (idx_q != IDX_W'(FRAME_BYTES - 1)) begin
              idx_d = idx_q + 1'b1;
            end
          end else begin
            frame_d[idx_q] = '0;
            in_frame_d     = 1'b0;
            idx_d          = '0;
            closing        = 1'b1;
          end
        end else if (item_i.rx_byte == cfg_i.start_marker) begin
          in_frame_d = 1'b1;
        end
      end
    end
    link_d     = accept ? (link_tmp && !(cnt_d > cfg_i.idle_timeout_ms)) : link_q;
    reported_d = accept ? link_d : reported_q;
  end

  // Position slots past the end of the buffer read as zero.
  if (POSITION_HIGH_INDEX < FRAME_BYTES) begin : g_hi
    assign pos_hi = frame_d[POSITION_HIGH_INDEX];
  end else begin : g_hi_none
    assign pos_hi = '0;
  end
  if (POSITION_HIGH_INDEX + 1 < FRAME_BYTES) begin : g_lo
    assign pos_lo = frame_d[POSITION_HIGH_INDEX + 1];
  end else begin : g_lo_none
    assign pos_lo = '0;
  end

  assign raw_d  = {pos_hi, pos_lo};
  assign held_d = closing ? raw_d : held_q;

  always_comb begin
    entry_o.frame_done    = closing;
    entry_o.raw_position  = raw_d;
    entry_o.held_position = held_d;
    entry_o.link_up       = link_d;
    entry_o.link_changed  = link_d != reported_q;
  end
  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < FRAME_BYTES; s++) begin
        frame_q[s] <= '0;
      end
      idx_q      <= '0;
      in_frame_q <= 1'b0;
      held_q     <= '0;
      cnt_q      <= '0;
      link_q     <= 1'b0;
      reported_q <= 1'b1;
    end else begin
      frame_q    <= frame_d;
      idx_q      <= idx_d;
      in_frame_q <= in_frame_d;
      held_q     <= held_d;
      cnt_q      <= cnt_d;
      link_q     <= link_d;
      reported_q <= reported_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(FRAME_BYTES - 1))
    else $error("write index ran past the last buffer slot");

  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && closing) |=> (!in_frame_q && idx_q == '0))
    else $error("closing a frame did not reset the write index");

  a_change_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && entry_o.link_changed) |=> (reported_q != $past(reported_q)))
    else $error("link change reported without a report update");

endmodule

`default_nettype wire

FILE: hw/rtl/efr_fifo.sv
// ----------------------------------------------------------------------------
// efr_fifo: short queue between front and back end
// Holds classified records so that each side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire efr_pkg::q_entry_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_ready_i,
  output logic                   pop_valid_o,
  output efr_pkg::q_entry_t      pop_data_o
);
  import efr_pkg::*;

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              pop;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  assign full_o      = count_q == QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o = count_q != '0;
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    unique case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");

endmodule

`default_nettype wire

FILE: hw/rtl/efr_back.sv
// ----------------------------------------------------------------------------
// efr_back: position clamp and heading scaler
// Two-stage pipeline: clamp and multiply, then offset and saturate into
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire efr_pkg::cfg_t     cfg_i,
  input  wire logic              pop_valid_i,
  input  wire efr_pkg::q_entry_t pop_data_i,
  output logic                   pop_ready_o,
  efr_out_if.source              result_o
);
  import efr_pkg::*;

  // Stage one.
  logic              s1_valid_q;
  logic [PROD_W-1:0] s1_prod_q;
  logic [POS_W-1:0]  s1_clamped_q, s1_raw_q;
  logic              s1_done_q, s1_link_q, s1_changed_q;
  // Result register.
  logic                     s2_valid_q;
  logic [POS_W-1:0]         s2_clamped_q, s2_raw_q;
  logic signed [HEAD_W-1:0] s2_head_q;
  logic                     s2_done_q, s2_link_q, s2_changed_q;

  logic                     s2_en, s1_en;
  logic [POS_W-1:0]         upper, clamped;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] sat;

  assign s2_en       = !s2_valid_q || result_o.ready;
  assign s1_en       = !s1_valid_q || s2_en;
  assign pop_ready_o = s1_en;

  // Upper limit first, lower limit last, so crossed limits give the minimum.
  assign upper   = (pop_data_i.held_position > cfg_i.position_max) ?
                   cfg_i.position_max : pop_data_i.held_position;
  assign clamped = (upper < cfg_i.position_min) ? cfg_i.position_min : upper;

  assign diff = signed'({2'b00, s1_prod_q}) -
                signed'({{(DIFF_W - OFFSET_W){1'b0}}, cfg_i.heading_offset});

  always_comb begin
    priority if (diff > HEAD_MAX) begin
      sat = HEAD_MAX;
    end else if (diff < HEAD_MIN) begin
      sat = HEAD_MIN;
    end else begin
      sat = diff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_prod_q    <= clamped * cfg_i.heading_gain;
      s1_clamped_q <= clamped;
      s1_raw_q     <= pop_data_i.raw_position;
      s1_done_q    <= pop_data_i.frame_done;
      s1_link_q    <= pop_data_i.link_up;
      s1_changed_q <= pop_data_i.link_changed;
    end
    if (s2_en) begin
      s2_head_q    <= sat[HEAD_W-1:0];
      s2_clamped_q <= s1_clamped_q;
      s2_raw_q     <= s1_raw_q;
      s2_done_q    <= s1_done_q;
      s2_link_q    <= s1_link_q;
      s2_changed_q <= s1_changed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= pop_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  assign result_o.valid            = s2_valid_q;
  assign result_o.frame_done       = s2_done_q;
  assign result_o.raw_position     = s2_raw_q;
  assign result_o.clamped_position = s2_clamped_q;
  assign result_o.heading_q16      = s2_head_q;
  assign result_o.link_up          = s2_link_q;
  assign result_o.link_changed     = s2_changed_q;

endmodule

`default_nettype wire

FILE: hw/rtl/encoder_frame_receiver_heading.sv
// ----------------------------------------------------------------------------
// encoder_frame_receiver_heading: serial encoder framer with heading output
// Frames start-marker delimited bytes, extracts the encoder position and
// turns it into a Q16 heading while watching the link for idle timeouts.
// ----------------------------------------------------------------------------
// Each input beat is either a received byte or a one-millisecond tick, and
// each one produces exactly one result beat, in order. The block takes one
// input beat every clock cycle while its queue is not full. The edge that
// accepts an input beat writes its record into the queue, from where it
// is loaded into the clamp-and-multiply stage and then into the result
// register that offers the result beat. The 16x16 heading multiplier
// behind the clamp in the back end is the deepest path. The front end
// updates the frame buffer and link state in the cycle of acceptance and
// hands a record to a two-entry queue, so a stalled result port only stops
// input once both back-end stages and that queue are full. Register writes
// complete in one beat and are meant for moments when no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module encoder_frame_receiver_heading (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  efr_in_if.sink    item_i,
  efr_out_if.source result_o,
  efr_cfg_if.sink   cfg_i
);
  import efr_pkg::*;

  cfg_t     cfg_q;
  q_entry_t push_entry, pop_entry;
  logic     push, queue_full, pop_valid, pop_ready;

  // Register file: every write beat is taken at once. Indexes beyond the
  // list are accepted and dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker    <= RST_START_MARKER;
      cfg_q.position_min    <= RST_POSITION_MIN;
      cfg_q.position_max    <= RST_POSITION_MAX;
      cfg_q.heading_gain    <= RST_HEADING_GAIN;
      cfg_q.heading_offset  <= RST_HEADING_OFFSET;
      cfg_q.idle_timeout_ms <= RST_IDLE_TIMEOUT_MS;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_START_MARKER:    cfg_q.start_marker    <= cfg_i.data[BYTE_W-1:0];
        REG_POSITION_MIN:    cfg_q.position_min    <= cfg_i.data[POS_W-1:0];
        REG_POSITION_MAX:    cfg_q.position_max    <= cfg_i.data[POS_W-1:0];
        REG_HEADING_GAIN:    cfg_q.heading_gain    <= cfg_i.data[GAIN_W-1:0];
        REG_HEADING_OFFSET:  cfg_q.heading_offset  <= cfg_i.data[OFFSET_W-1:0];
        REG_IDLE_TIMEOUT_MS: cfg_q.idle_timeout_ms <= cfg_i.data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: framing, buffer, idle counter and link report.
  efr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cfg_i        (cfg_q),
    .queue_full_i (queue_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Decoupling queue.
  efr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (queue_full),
    .pop_ready_i (pop_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_entry)
  );

  // Back end: clamp, scale, offset and saturate.
  efr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_entry),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/efr_result_checker.sv
// ----------------------------------------------------------------------------
// efr_result_checker: result checker for the encoder frame receiver
// Watches the item, result and register channels. It keeps its own copy of
// the framer state, works out the result of every accepted item and compares
// each result beat with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efr_result_checker
  import efr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  efr_in_if           item,
  efr_out_if          result,
  efr_cfg_if          cfg,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic                     frame_done;
    logic [POS_W-1:0]         raw_position;
    logic [POS_W-1:0]         clamped_position;
    logic signed [HEAD_W-1:0] heading_q16;
    logic                     link_up;
    logic                     link_changed;
  } heading_result_t;

  localparam longint HEADING_TOP    = (longint'(1) <<< (HEAD_W - 1)) - 1;
  localparam longint HEADING_BOTTOM = -(longint'(1) <<< (HEAD_W - 1));

  cfg_t              regs;
  logic              in_frame;
  int unsigned       write_idx;
  logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
  logic [POS_W-1:0]  held_pos;
  logic [COUNT_W-1:0] idle_count;
  logic              link_state;
  logic              link_reported;

  heading_result_t   pending_results [$];
  heading_result_t   oldest;

  // Slots past the end of the buffer read as zero.
  function automatic logic [POS_W-1:0] buffered_position();
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    hi = (POSITION_HIGH_INDEX < FRAME_BYTES) ? frame_buf[POSITION_HIGH_INDEX] : '0;
    lo = (POSITION_HIGH_INDEX + 1 < FRAME_BYTES) ? frame_buf[POSITION_HIGH_INDEX + 1] : '0;
    return {hi, lo};
  endfunction

  function automatic heading_result_t advance_framer(op_e op, logic [BYTE_W-1:0] rx);
    heading_result_t  r;
    logic [POS_W-1:0] clamped;
    longint           scaled;
    r = '0;
    if (op == OP_TICK) begin
      if (idle_count != '1) idle_count++;
    end else begin
      link_state = 1'b1;
      idle_count = '0;
      if (in_frame) begin
        if (rx != regs.start_marker) begin
          if (write_idx < FRAME_BYTES) frame_buf[write_idx] = rx;
          if (write_idx < FRAME_BYTES - 1) write_idx++;
        end else begin
          if (write_idx < FRAME_BYTES) frame_buf[write_idx] = '0;
          in_frame     = 1'b0;
          write_idx    = 0;
          r.frame_done = 1'b1;
          held_pos     = buffered_position();
        end
      end else if (rx == regs.start_marker) begin
        in_frame = 1'b1;
      end
    end

    if (link_state && idle_count > regs.idle_timeout_ms) link_state = 1'b0;
    if (link_state != link_reported) begin
      r.link_changed = 1'b1;
      link_reported  = link_state;
    end

    // The lower limit is applied last, so it wins when the limits cross.
    clamped = held_pos;
    if (clamped > regs.position_max) clamped = regs.position_max;
    if (clamped < regs.position_min) clamped = regs.position_min;

    scaled = longint'(clamped) * longint'(regs.heading_gain) - longint'(regs.heading_offset);
    if (scaled > HEADING_TOP) scaled = HEADING_TOP;
    if (scaled < HEADING_BOTTOM) scaled = HEADING_BOTTOM;

    r.raw_position     = buffered_position();
    r.clamped_position = clamped;
    r.heading_q16      = scaled[HEAD_W-1:0];
    r.link_up          = link_state;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.start_marker    = RST_START_MARKER;
      regs.position_min    = RST_POSITION_MIN;
      regs.position_max    = RST_POSITION_MAX;
      regs.heading_gain    = RST_HEADING_GAIN;
      regs.heading_offset  = RST_HEADING_OFFSET;
      regs.idle_timeout_ms = RST_IDLE_TIMEOUT_MS;
      in_frame      = 1'b0;
      write_idx     = 0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      held_pos      = '0;
      idle_count    = '0;
      link_state    = 1'b0;
      link_reported = 1'b1;
      pending_results.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_e'(cfg.index))
          REG_START_MARKER:    regs.start_marker    = cfg.data[BYTE_W-1:0];
          REG_POSITION_MIN:    regs.position_min    = cfg.data[POS_W-1:0];
          REG_POSITION_MAX:    regs.position_max    = cfg.data[POS_W-1:0];
          REG_HEADING_GAIN:    regs.heading_gain    = cfg.data[GAIN_W-1:0];
          REG_HEADING_OFFSET:  regs.heading_offset  = cfg.data[OFFSET_W-1:0];
          REG_IDLE_TIMEOUT_MS: regs.idle_timeout_ms = cfg.data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (item.valid && item.ready) begin
        pending_results.push_back(advance_framer(op_e'(item.opcode), item.rx_byte));
      end

      if (result.valid && result.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          oldest = pending_results.pop_front();
          check_field("frame_done", result.frame_done, oldest.frame_done);
          check_field("raw_position", result.raw_position, oldest.raw_position);
          check_field("clamped_position", result.clamped_position,
                      oldest.clamped_position);
          check_field("heading_q16", $signed(result.heading_q16), oldest.heading_q16);
          check_field("link_up", result.link_up, oldest.link_up);
          check_field("link_changed", result.link_changed, oldest.link_changed);
        end
      end

      pending_o = pending_results.size();
    end
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the encoder frame receiver
// Drives bytes and ticks through the item channel, programs the registers
// between phases and gives the verdict from the result checker's count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import efr_pkg::*;

  // The run is cut off after this long no matter what.
  localparam int unsigned TIMEOUT_NS = 400_000;

  // Length of the long receiver hold-off used to back the block up.
  localparam int unsigned HOLD_CYCLES = 300;

  // Items in each random phase.
  localparam int unsigned PHASE_ITEMS = 110;

  logic clk = 1'b0;
  logic rst_n;

  efr_in_if  item_ch ();
  efr_out_if result_ch ();
  efr_cfg_if cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;

  // Chance in percent that a side idles in a given cycle.
  int unsigned tx_idle_pct = 22;
  int unsigned rx_idle_pct = 22;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  // Start marker as currently programmed, so frames can be built around it.
  logic [BYTE_W-1:0] marker = RST_START_MARKER;
  int unsigned       items_sent = 0;

  encoder_frame_receiver_heading dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  efr_result_checker result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .item         (item_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one item, after a random number of idle cycles, and returns at
  // the falling edge after the beat was taken. Valid is left high so that
  // back-to-back beats never see it dropped and raised in the same step.
  task automatic send_item(op_e op, logic [BYTE_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.opcode  <= op;
    item_ch.rx_byte <= value;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // A burst of ticks. The byte field carries noise, which the block ignores.
  task automatic send_ticks(int unsigned count);
    repeat (count) send_item(OP_TICK, BYTE_W'($urandom));
  endtask

  // Drops valid and waits until every result has come back. The extra
  // waits that follow cover the pipeline before a register is touched.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Programs a complete register setting while the block is idle.
  task automatic apply_setting(logic [BYTE_W-1:0] start_byte, logic [POS_W-1:0] pos_min,
                               logic [POS_W-1:0] pos_max, logic [GAIN_W-1:0] gain,
                               logic [OFFSET_W-1:0] offset, logic [COUNT_W-1:0] timeout);
    settle();
    write_reg(REG_START_MARKER, CFG_DATA_W'(start_byte));
    write_reg(REG_POSITION_MIN, CFG_DATA_W'(pos_min));
    write_reg(REG_POSITION_MAX, CFG_DATA_W'(pos_max));
    write_reg(REG_HEADING_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_HEADING_OFFSET, CFG_DATA_W'(offset));
    write_reg(REG_IDLE_TIMEOUT_MS, CFG_DATA_W'(timeout));
    marker = start_byte;
  endtask

  // Random traffic. Most of it is well-formed frames with random content,
  // since only those get a position latched. Body lengths run past the
  // buffer now and then so the write index saturates. The rest is tick
  // bursts to work the idle timeout, stray bytes and frames that never see
  // their closing marker.
  task automatic run_phase(int unsigned count);
    int unsigned       target;
    int unsigned       pick;
    int unsigned       body_len;
    logic [BYTE_W-1:0] body_byte;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        body_len = ($urandom_range(3) == 0) ? $urandom_range(0, 16) : $urandom_range(10, 14);
        send_item(OP_BYTE, marker);
        repeat (body_len) begin
          body_byte = BYTE_W'($urandom);
          if (body_byte == marker) body_byte = body_byte ^ 8'h01;
          send_item(OP_BYTE, body_byte);
        end
        send_item(OP_BYTE, marker);
      end else if (pick < 82) begin
        send_ticks($urandom_range(1, 7));
      end else if (pick < 92) begin
        // A stray byte. It may equal the marker and open a frame by itself.
        send_item(OP_BYTE, BYTE_W'($urandom));
      end else begin
        // A broken frame: unfiltered content and no closing marker here.
        send_item(OP_BYTE, marker);
        repeat ($urandom_range(1, 15)) send_item(OP_BYTE, BYTE_W'($urandom));
      end
    end
  endtask

  // The receiver runs in its own process. It stalls at random, and once
  // asked it holds ready low for a long stretch of counted cycles while the
  // sender keeps offering beats.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.opcode  = OP_BYTE;
    item_ch.rx_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_START_MARKER;
    cfg_ch.data     = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset setting. The first tick reports a link
    // change, since the link starts down but was last reported up, and its
    // byte field is all ones to show it is ignored. A stray byte outside a
    // frame brings the link up and is dropped.
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, 8'h55);
    // A frame whose position bytes are all ones, clamped to the upper
    // limit. Three more bytes push the index to the last slot, where the
    // later ones overwrite, and the closing marker writes a zero there.
    send_item(OP_BYTE, marker);
    for (int i = 0; i < 8; i++) send_item(OP_BYTE, (i % 2 != 0) ? 8'hFF : 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h12);
    send_item(OP_BYTE, 8'h34);
    send_item(OP_BYTE, 8'h56);
    send_item(OP_BYTE, marker);
    // A short frame leaves the position slots untouched, so the old
    // position is latched again.
    send_item(OP_BYTE, marker);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, marker);
    send_ticks(1);

    // Random traffic at the reset setting.
    run_phase(PHASE_ITEMS);

    // Widest limits, largest gain and no offset drive the heading into
    // positive saturation. A zero timeout drops the link after one tick.
    apply_setting(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 24'h000000, 16'd0);
    run_phase(PHASE_ITEMS);

    // Crossed limits, where the lower one wins, and zero gain with the
    // largest offset for negative saturation. The link never drops.
    apply_setting(8'hFF, 16'd5000, 16'd100, 16'h0000, 24'hFFFFFF, 16'hFFFF);
    run_phase(PHASE_ITEMS);

    // Both limits at the top, random scaling, and the shortest nonzero timeout.
    // The receiver holds off for a long stretch while the sender never
    // pauses, so the queue fills and the block stalls its input.
    apply_setting(BYTE_W'($urandom), 16'hFFFF, 16'hFFFF, GAIN_W'($urandom),
                  OFFSET_W'($urandom), 16'd1);
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    run_phase(PHASE_ITEMS);
    tx_idle_pct = 22;

    // Random limits and scaling with a long stretch where neither side idles.
    apply_setting(BYTE_W'($urandom), POS_W'($urandom_range(0, 2000)),
                  POS_W'($urandom_range(2000, 65535)), GAIN_W'($urandom),
                  OFFSET_W'($urandom), COUNT_W'($urandom_range(2, 5)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(PHASE_ITEMS);
    tx_idle_pct = 22;
    rx_idle_pct = 22;

    // Back to the reset scaling, written explicitly, with a short timeout.
    apply_setting(RST_START_MARKER, RST_POSITION_MIN, RST_POSITION_MAX,
                  RST_HEADING_GAIN, RST_HEADING_OFFSET, 16'd3);
    run_phase(PHASE_ITEMS);

    // Drain everything, then give the pipeline time to show any extra beat.
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS encoder_frame_receiver_heading");
    end else begin
      $display("FAIL encoder_frame_receiver_heading");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL encoder_frame_receiver_heading");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/efr_pkg.sv
hw/rtl/efr_if.sv
hw/rtl/efr_front.sv
hw/rtl/efr_fifo.sv
hw/rtl/efr_back.sv
hw/rtl/encoder_frame_receiver_heading.sv
tb/efr_result_checker.sv
tb/tb.sv
